### rtl/tpv_pkg.sv
// Package with constants, tables and the SHA-256 round functions of the tunnel packet verifier.
`timescale 1ns / 1ps
package tpv_pkg;
  localparam int KEY_BYTES_DEF = 32;
  localparam int TAG_BYTES_DEF = 16;
  localparam int FIXED_HDR = 8;
  localparam logic [16:0] MAX_LEN = 17'd65535;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_FLOW = 3'd3,
    ST_BAD_MAC = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_MAGIC = 3'd0,
    REG_FLOW = 3'd1,
    REG_KEY0 = 3'd2,
    REG_KEY1 = 3'd3,
    REG_KEY2 = 3'd4,
    REG_KEY3 = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

### rtl/tpv_sha_core.sv
// Iterative SHA-256 compression unit: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
module tpv_sha_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [511:0]   block,
  input  logic [255:0]   chain_in,
  output logic [255:0]   chain_out,
  output tpv_pkg::core_ctl_t ctl
);
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0] round;
  logic busy, add_step, done;
  logic [31:0] t1, t2, s0, s1, wnew;

  assign s0 = tpv_pkg::rotr(w[1], 7) ^ tpv_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = tpv_pkg::rotr(w[14], 17) ^ tpv_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign t1 = h + (tpv_pkg::rotr(e, 6) ^ tpv_pkg::rotr(e, 11) ^ tpv_pkg::rotr(e, 25))
            + ((e & f) ^ (~e & g)) + tpv_pkg::k_const(round) + w[0];
  assign t2 = (tpv_pkg::rotr(a, 2) ^ tpv_pkg::rotr(a, 13) ^ tpv_pkg::rotr(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      add_step <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= add_step;
      add_step <= busy && !start && (round == 6'd63);
      if (start) begin
        busy <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32 * i -: 32];
      {a, b, c, d, e, f, g, h} <= chain_in;
      chain_out <= chain_in;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wnew;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end else if (add_step) begin
      chain_out <= {chain_out[255:224] + a, chain_out[223:192] + b,
                    chain_out[191:160] + c, chain_out[159:128] + d,
                    chain_out[127:96] + e, chain_out[95:64] + f,
                    chain_out[63:32] + g, chain_out[31:0] + h};
    end
  end

  always_comb begin
    ctl.start = start;
    ctl.busy = busy | add_step | done;
    ctl.done = done;
  end
endmodule

### rtl/tunnel_packet_verifier_top.sv
// Top level of the tunnel packet verifier: byte sequencer, HMAC control and result register.
// Each byte passes through the absorb and payload states, and the next byte waits for the
// result register to empty; the first byte of a packet or a byte that fills a 64-byte block
// adds a compression on the single shared round unit.
// The last byte of a good-length packet adds up to four more compressions before the verdict.
// Reset is synchronous and active high; it clears configuration and packet state.
`timescale 1ns / 1ps
module tunnel_packet_verifier_top #(
  parameter int KEY_BYTES = tpv_pkg::KEY_BYTES_DEF,
  parameter int TAG_BYTES = tpv_pkg::TAG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_verdict,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [15:0] payload_length,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int HDR_LEN = tpv_pkg::FIXED_HDR + TAG_BYTES;
  localparam logic [16:0] POS_MAX_L = tpv_pkg::POS_MAX;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_IKEY   = 11'b00000000010,
    S_ABS    = 11'b00000000100,
    S_BLK    = 11'b00000001000,
    S_PAY    = 11'b00000010000,
    S_FIN    = 11'b00000100000,
    S_FIN2   = 11'b00001000000,
    S_OKEY   = 11'b00010000000,
    S_OUTER  = 11'b00100000000,
    S_VERD   = 11'b01000000000,
    S_WAIT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [15:0] magic_word, expected_flow;
  logic [255:0] key;
  logic [16:0] byte_position;
  logic [63:0] header_fields;
  logic [255:0] received_tag;
  logic [255:0] hash_chain;
  logic [511:0] message_block;
  logic [2:0] error_code;
  logic [7:0] cur_byte;
  logic cur_last;
  logic [16:0] cur_pos;
  logic [16:0] hcount;
  logic [255:0] inner_digest;
  logic core_start;
  logic [511:0] core_block;
  logic [255:0] core_chain_in, core_out;
  tpv_pkg::core_ctl_t core_ctl;
  logic verd_pend;
  logic [2:0] verd_status;
  logic [15:0] verd_plen;
  logic verd_short;

  tpv_sha_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .block(core_block),
    .chain_in(core_chain_in), .chain_out(core_out), .ctl(core_ctl)
  );

  function automatic logic [511:0] key_block(input logic [255:0] k, input logic [7:0] pad);
    logic [511:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[511 - 8 * i -: 8] = ((i < KEY_BYTES) ? k[255 - 8 * i -: 8] : 8'd0) ^ pad;
    end
    return r;
  endfunction

  function automatic logic [16:0] hashed_count(input logic [16:0] n);
    if (n <= 17'(tpv_pkg::FIXED_HDR)) return n;
    if (n <= 17'(HDR_LEN)) return 17'(tpv_pkg::FIXED_HDR);
    return n - 17'(TAG_BYTES);
  endfunction

  logic [17:0] len;
  logic [63:0] bitlen;
  logic [5:0] fill;
  logic tag_diff;
  logic [511:0] pad_block;
  assign len = {1'b0, cur_pos} + 18'd1;
  assign fill = hcount[5:0];
  assign bitlen = ({47'd0, hcount} + 64'd64) << 3;

  always_comb begin
    tag_diff = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (i < TAG_BYTES) begin
        tag_diff = tag_diff | (core_out[255 - 8 * i -: 8] != received_tag[255 - 8 * i -: 8]);
      end
    end
    pad_block = message_block;
    for (int i = 0; i < 64; i++) begin
      if (i == fill) pad_block[511 - 8 * i -: 8] = 8'h80;
      else if (i > fill) pad_block[511 - 8 * i -: 8] = 8'h00;
    end
    if (fill < 6'd56) pad_block[63:0] = bitlen;
  end

  assign in_ready = (state == S_IDLE) && !out_valid && !verd_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
      expected_flow <= '0;
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpv_pkg::REG_MAGIC: magic_word <= cfg_data[15:0];
        tpv_pkg::REG_FLOW: expected_flow <= cfg_data[15:0];
        tpv_pkg::REG_KEY0: key[255:192] <= cfg_data;
        tpv_pkg::REG_KEY1: key[191:128] <= cfg_data;
        tpv_pkg::REG_KEY2: key[127:64] <= cfg_data;
        tpv_pkg::REG_KEY3: key[63:0] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    core_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      byte_position <= '0;
      header_fields <= '0;
      received_tag <= '0;
      hash_chain <= tpv_pkg::IV;
      error_code <= tpv_pkg::ST_OK;
      verd_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_byte <= data_byte;
            cur_last <= last;
            cur_pos <= byte_position;
            hcount <= hashed_count(byte_position);
            if (byte_position < POS_MAX_L) byte_position <= byte_position + 17'd1;
            if (byte_position == 17'd0) begin
              core_block <= key_block(key, 8'h36);
              core_chain_in <= tpv_pkg::IV;
              core_start <= 1'b1;
              state <= S_IKEY;
            end else begin
              state <= S_ABS;
            end
          end else if (verd_pend && !out_valid) begin
            state <= S_VERD;
          end
        end
        S_IKEY: begin
          if (core_ctl.done) begin
            hash_chain <= core_out;
            state <= S_ABS;
          end
        end
        S_ABS: begin
          if (cur_pos < 17'(tpv_pkg::FIXED_HDR)) begin
            header_fields[63 - 8 * cur_pos[2:0] -: 8] <= cur_byte;
          end
          if (cur_pos == 17'd1 && error_code == tpv_pkg::ST_OK &&
              {header_fields[63:56], cur_byte} != magic_word) begin
            error_code <= tpv_pkg::ST_BAD_MAGIC;
          end
          if (cur_pos == 17'd3 && error_code == tpv_pkg::ST_OK &&
              {header_fields[47:40], cur_byte} != expected_flow) begin
            error_code <= tpv_pkg::ST_BAD_FLOW;
          end
          if (cur_pos >= 17'(tpv_pkg::FIXED_HDR) && cur_pos < 17'(HDR_LEN)) begin
            received_tag[255 - 8 * (cur_pos[5:0] - 6'(tpv_pkg::FIXED_HDR)) -: 8] <= cur_byte;
          end
          if (cur_pos < tpv_pkg::MAX_LEN &&
              (cur_pos < 17'(tpv_pkg::FIXED_HDR) || cur_pos >= 17'(HDR_LEN))) begin
            message_block[511 - 8 * hcount[5:0] -: 8] <= cur_byte;
            if (hcount[5:0] == 6'd63) begin
              core_block <= {message_block[511:8], cur_byte};
              core_chain_in <= hash_chain;
              core_start <= 1'b1;
              state <= S_BLK;
            end else begin
              state <= S_PAY;
            end
          end else begin
            state <= S_PAY;
          end
        end
        S_BLK: begin
          if (core_ctl.done) begin
            hash_chain <= core_out;
            state <= S_PAY;
          end
        end
        S_PAY: begin
          if (!out_valid) begin
            if (cur_pos >= 17'(HDR_LEN)) begin
              out_valid <= 1'b1;
              is_verdict <= 1'b0;
              payload_byte <= cur_byte;
              status <= tpv_pkg::ST_OK;
              source_port <= '0;
              destination_port <= '0;
              payload_length <= '0;
            end
            if (!cur_last) begin
              state <= S_IDLE;
            end else if (len < 18'(HDR_LEN)) begin
              verd_status <= tpv_pkg::ST_TOO_SHORT;
              verd_short <= 1'b1;
              verd_plen <= '0;
              verd_pend <= 1'b1;
              state <= S_IDLE;
            end else begin
              verd_short <= 1'b0;
              verd_plen <= ((len - 18'(HDR_LEN)) > 18'd65535) ? 16'hFFFF
                           : 16'(len - 18'(HDR_LEN));
              if (error_code != tpv_pkg::ST_OK) begin
                verd_status <= error_code;
                verd_pend <= 1'b1;
                state <= S_IDLE;
              end else if (len > 18'(tpv_pkg::MAX_LEN)) begin
                verd_status <= tpv_pkg::ST_TOO_LONG;
                verd_pend <= 1'b1;
                state <= S_IDLE;
              end else begin
                hcount <= hashed_count(len[16:0]);
                state <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          core_chain_in <= hash_chain;
          core_block <= pad_block;
          if (fill >= 6'd56) begin
            message_block <= {448'd0, bitlen};
          end
          core_start <= 1'b1;
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (core_ctl.done) begin
            if (fill >= 6'd56) begin
              hash_chain <= core_out;
              core_chain_in <= core_out;
              core_block <= message_block;
              core_start <= 1'b1;
              hcount <= {hcount[16:6], 6'd0};
            end else begin
              inner_digest <= core_out;
              core_block <= key_block(key, 8'h5c);
              core_chain_in <= tpv_pkg::IV;
              core_start <= 1'b1;
              state <= S_OKEY;
            end
          end
        end
        S_OKEY: begin
          if (core_ctl.done) begin
            core_chain_in <= core_out;
            core_block <= {inner_digest, 8'h80, 184'd0, 64'd768};
            core_start <= 1'b1;
            state <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (core_ctl.done) begin
            verd_status <= tag_diff ? tpv_pkg::ST_BAD_MAC : tpv_pkg::ST_OK;
            verd_pend <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_VERD: begin
          out_valid <= 1'b1;
          is_verdict <= 1'b1;
          payload_byte <= '0;
          status <= verd_status;
          source_port <= verd_short ? 16'd0 : header_fields[31:16];
          destination_port <= verd_short ? 16'd0 : header_fields[15:0];
          payload_length <= verd_plen;
          verd_pend <= 1'b0;
          byte_position <= '0;
          header_fields <= '0;
          received_tag <= '0;
          hash_chain <= tpv_pkg::IV;
          error_code <= tpv_pkg::ST_OK;
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
